>>> src/skt_pkg.sv
// shared types and constants for the sorted key table
package skt_pkg;

	// default number of cells in the table
	localparam int TABLE_DEPTH_DEF = 16;

	// field widths
	localparam int KEY_W   = 16;
	localparam int VAL_W   = 16;
	localparam int POS_W   = 5;
	localparam int STAT_W  = 2;

	// item modes
	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_LOOKUP = 1'b1
	} mode_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_LOOKUP    = 2'd3
	} status_t;

	// one stored entry
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             kind;
		logic [VAL_W-1:0] payload;
	} entry_t;

	// control from the sequencer to every cell
	typedef struct packed {
		logic cmp;
		logic ins;
	} cell_ctrl_t;

endpackage

>>> src/skt_if.sv
// request and response channel interfaces of the sorted key table
interface skt_req_if import skt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [KEY_W-1:0] key;
	logic             kind;
	logic [VAL_W-1:0] payload;

	modport source (output valid, mode, key, kind, payload, input ready);
	modport sink   (input valid, mode, key, kind, payload, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic              found;
	logic [POS_W-1:0]  position;
	logic              found_kind;
	logic [VAL_W-1:0]  found_payload;
	logic [POS_W-1:0]  entry_count;

	modport source (output valid, status, found, position, found_kind, found_payload,
		entry_count, input ready);
	modport sink   (input valid, status, found, position, found_kind, found_payload,
		entry_count, output ready);
endinterface

>>> src/skt_cell.sv
// one table cell: holds an entry, compares it and shifts it to the next cell
module skt_cell import skt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       occ,
	input  entry_t     item,
	input  logic       prev_ge,
	input  entry_t     prev_entry,
	output entry_t     entry,
	output logic       ge,
	output logic       match
);

	entry_t entry_q;
	logic   ge_q;
	logic   match_q;

	// compare flags, captured once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ge_q    <= 1'b0;
			match_q <= 1'b0;
		end else if (ctrl.cmp) begin
			match_q <= occ && (entry_q.key == item.key);
			ge_q    <= !occ || (entry_q.key > item.key);
		end
	end

	// entry storage: load the new entry at the insert point, shift up above it
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (ge_q && !prev_ge) begin
				entry_q <= item;
			end else if (prev_ge) begin
				entry_q <= prev_entry;
			end
		end
	end

	assign entry = entry_q;
	assign ge    = ge_q;
	assign match = match_q;

endmodule

>>> src/sorted_key_table_insert_find.sv
// Sorted key table with duplicate rejection, built as a chain of entry cells.
// req carries one item per transfer: mode 0 inserts (key, kind, payload),
// mode 1 looks up key. rsp returns exactly one result per item: status,
// found flag, position, the matching entry's kind and payload, and the
// entry count after the item. Entries are kept in ascending key order.
// Each item passes through the transfer, a compare step in which every cell
// compares its key against the item, and an update step in which the cells
// shift up past the insert point and the result is registered. rsp.valid
// rises as the update step registers the result; a new item is taken once
// the previous one has reached the output register.
// A stalled rsp holds its result; the table then waits with the finished
// item in the update step until the output register frees up.
// Reset empties the table at once (count goes to zero); cell contents are
// left as they are and only entries below the count are ever used.
module sorted_key_table_insert_find import skt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	state_t                 state_q;
	logic                   mode_q;
	entry_t                 item_q;
	logic [CW-1:0]          count_q;
	cell_ctrl_t             ctrl;
	entry_t                 entries [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] ge_vec;
	logic [TABLE_DEPTH-1:0] match_vec;
	logic [TABLE_DEPTH-1:0] ins_vec;
	logic [TABLE_DEPTH-1:0] occ_vec;

	logic          out_valid_q;
	status_t       status_q;
	logic          found_q;
	logic [POS_W-1:0] position_q;
	logic          found_kind_q;
	logic [VAL_W-1:0] found_payload_q;
	logic [POS_W-1:0] entry_count_q;

	logic          found;
	logic          full;
	logic          do_ins;
	logic          load_out;
	logic [CW-1:0] match_pos;
	logic [CW-1:0] ins_pos;
	logic [CW-1:0] pos;
	logic [CW-1:0] next_count;
	entry_t        match_entry;
	status_t       status_d;
	logic [CW+POS_W-1:0] pos_ext;
	logic [CW+POS_W-1:0] count_ext;

	// chain of cells
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		assign occ_vec[i] = count_q > CW'(i);
		if (i == 0) begin : g_first
			assign ins_vec[i] = ge_vec[i];
			skt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.occ        (occ_vec[i]),
				.item       (item_q),
				.prev_ge    (1'b0),
				.prev_entry (item_q),
				.entry      (entries[i]),
				.ge         (ge_vec[i]),
				.match      (match_vec[i])
			);
		end else begin : g_next
			assign ins_vec[i] = ge_vec[i] && !ge_vec[i-1];
			skt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.occ        (occ_vec[i]),
				.item       (item_q),
				.prev_ge    (ge_vec[i-1]),
				.prev_entry (entries[i-1]),
				.entry      (entries[i]),
				.ge         (ge_vec[i]),
				.match      (match_vec[i])
			);
		end
	end

	// one-hot reduction of the cell flags
	always_comb begin
		match_pos   = '0;
		ins_pos     = '0;
		match_entry = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (match_vec[i]) begin
				match_pos   = match_pos | CW'(i);
				match_entry = match_entry | entries[i];
			end
			if (ins_vec[i]) begin
				ins_pos = ins_pos | CW'(i);
			end
		end
	end

	// result selection
	always_comb begin
		found  = |match_vec;
		full   = count_q == CW'(TABLE_DEPTH);
		do_ins = (mode_q == MODE_INSERT) && !found && !full;
		if (found) begin
			pos      = match_pos;
			status_d = (mode_q == MODE_LOOKUP) ? ST_LOOKUP : ST_DUPLICATE;
		end else if (mode_q == MODE_LOOKUP) begin
			pos      = count_q;
			status_d = ST_LOOKUP;
		end else if (full) begin
			pos      = count_q;
			status_d = ST_FULL;
		end else begin
			pos      = ins_pos;
			status_d = ST_INSERTED;
		end
		next_count = count_q + CW'(do_ins);
		pos_ext    = {{POS_W{1'b0}}, pos};
		count_ext  = {{POS_W{1'b0}}, next_count};
	end

	// cell control
	assign load_out = (state_q == S_UPD) && (!out_valid_q || rsp.ready);
	assign ctrl.cmp = state_q == S_CMP;
	assign ctrl.ins = load_out && do_ins;

	// item register
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q         <= req.mode;
			item_q.key     <= req.key;
			item_q.kind    <= req.kind;
			item_q.payload <= req.payload;
		end
	end

	// sequencer, count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			out_valid_q     <= 1'b0;
			status_q        <= ST_INSERTED;
			found_q         <= 1'b0;
			position_q      <= '0;
			found_kind_q    <= 1'b0;
			found_payload_q <= '0;
			entry_count_q   <= '0;
		end else begin
			// result taken and nothing new to load
			if (out_valid_q && rsp.ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (load_out) begin
						state_q         <= S_IDLE;
						count_q         <= next_count;
						out_valid_q     <= 1'b1;
						status_q        <= status_d;
						found_q         <= found;
						position_q      <= pos_ext[POS_W-1:0];
						found_kind_q    <= found ? match_entry.kind : 1'b0;
						found_payload_q <= found ? match_entry.payload : '0;
						entry_count_q   <= count_ext[POS_W-1:0];
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready         = state_q == S_IDLE;
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.found         = found_q;
	assign rsp.position      = position_q;
	assign rsp.found_kind    = found_kind_q;
	assign rsp.found_payload = found_payload_q;
	assign rsp.entry_count   = entry_count_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_match_unique: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> $onehot0(match_vec))
		else $error("key matches more than one cell");

	a_ins_unique: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> $onehot0(ins_vec))
		else $error("more than one insert point");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not bump the entry count");

endmodule
